FILE: rtl/aclimd_pkg.sv
package aclimd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int RUN_W    = 4;
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [SAMPLE_W-1:0] SATURATED_SAMPLE = 12'd4095;
    localparam logic [RUN_W-1:0]    RUN_MAX          = 4'd15;

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STOP_CURRENT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_DIFFERENCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_RUN_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_RUN_LENGTH = 2'd3;

    localparam logic [SAMPLE_W-1:0] RST_STOP_CURRENT    = 12'd2048;
    localparam logic [SAMPLE_W-1:0] RST_RISE_DIFFERENCE = 12'd100;
    localparam logic [RUN_W-1:0]    RST_RISE_RUN_LENGTH = 4'd3;
    localparam logic [RUN_W-1:0]    RST_OVER_RUN_LENGTH = 4'd10;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SAMPLE_W-1:0] adc_sample;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_current;
        logic                limit_reached;
        logic                sample_taken;
    } t_out;

    typedef struct packed {
        logic [SAMPLE_W-1:0] stop_current;
        logic [SAMPLE_W-1:0] rise_difference;
        logic [RUN_W-1:0]    rise_run_length;
        logic [RUN_W-1:0]    over_run_length;
    } t_cfg;

    typedef struct packed {
        logic                judge;
        logic                restart;
        logic                clear;
        logic [SAMPLE_W-1:0] mean;
    } t_judge_cmd;

endpackage

FILE: rtl/aclimd_cell.sv
module aclimd_cell
    import aclimd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_data,
    output logic [SAMPLE_W-1:0] o_data
);

    logic [SAMPLE_W-1:0] r_data;
    logic [SAMPLE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_shift) begin
            n_data = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: rtl/aclimd_judge.sv
module aclimd_judge
    import aclimd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_judge_cmd i_cmd,
    input  t_cfg       i_cfg,
    output logic       o_flag
);

    logic [SAMPLE_W-1:0] r_last_mean;
    logic [RUN_W-1:0]    r_over_run;
    logic [RUN_W-1:0]    r_rise_run;
    logic                r_flag;

    logic [SAMPLE_W-1:0] n_last_mean;
    logic [RUN_W-1:0]    n_over_run;
    logic [RUN_W-1:0]    n_rise_run;
    logic                n_flag;
    logic [SAMPLE_W-1:0] rise;

    always_comb begin
        n_last_mean = r_last_mean;
        n_over_run  = r_over_run;
        n_rise_run  = r_rise_run;
        n_flag      = r_flag;
        rise        = i_cmd.mean - r_last_mean;
        if (i_cmd.restart) begin
            n_last_mean = '0;
            n_over_run  = '0;
            n_rise_run  = '0;
            n_flag      = 1'b0;
        end else if (i_cmd.clear) begin
            n_flag = 1'b0;
        end else if (i_cmd.judge) begin
            if (i_cmd.mean > i_cfg.stop_current) begin
                if (r_over_run < RUN_MAX) begin
                    n_over_run = r_over_run + 1'b1;
                end
                if (n_over_run >= i_cfg.over_run_length) begin
                    n_flag = 1'b1;
                end
            end else begin
                n_over_run = '0;
            end
            if ((i_cmd.mean > r_last_mean) && (rise > i_cfg.rise_difference)) begin
                if (r_rise_run < RUN_MAX) begin
                    n_rise_run = r_rise_run + 1'b1;
                end
            end else begin
                // a rise run that ends long enough latches the flag
                if (r_rise_run > i_cfg.rise_run_length) begin
                    n_flag = 1'b1;
                end
                n_rise_run = '0;
            end
            n_last_mean = i_cmd.mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mean <= '0;
            r_over_run  <= '0;
            r_rise_run  <= '0;
            r_flag      <= 1'b0;
        end else if (i_en) begin
            r_last_mean <= n_last_mean;
            r_over_run  <= n_over_run;
            r_rise_run  <= n_rise_run;
            r_flag      <= n_flag;
        end
    end

    assign o_flag = n_flag;

endmodule

FILE: rtl/actuator_current_limit_detector_unit.sv
// channel   direction  signals                                    transfer when
// in        input      i_in_valid, o_in_ready, i_in_data (t_in)   i_in_valid && o_in_ready
// out       output     o_out_valid, i_out_ready, o_out_data       o_out_valid && i_out_ready
// cfg       input      i_cfg_we, i_cfg_index, i_cfg_data          i_cfg_we
//
// one item per cycle sustained while the output is not stalled: a non-saturated sample
// shifts into the cell chain and the running total on transfer, and the mean (reciprocal
// multiply) is judged and registered into the output stage when the first stage advances.
// synchronous active-low reset clears the cells, total, run counters and flag.
// a stalled output holds the first stage, so input is still taken while one result waits.
module actuator_current_limit_detector_unit
    import aclimd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data
);

    localparam int TOT_W   = $clog2(WINDOW_DEPTH * 4095 + 1);
    localparam int SHIFT   = TOT_W + $clog2(WINDOW_DEPTH);
    localparam int RECIP_W = TOT_W + 1;
    localparam int RECIP   = ((1 << SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int PROD_W  = TOT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    // configuration
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_current    <= RST_STOP_CURRENT;
            r_cfg.rise_difference <= RST_RISE_DIFFERENCE;
            r_cfg.rise_run_length <= RST_RISE_RUN_LENGTH;
            r_cfg.over_run_length <= RST_OVER_RUN_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STOP_CURRENT:    r_cfg.stop_current    <= i_cfg_data;
                CFG_RISE_DIFFERENCE: r_cfg.rise_difference <= i_cfg_data;
                CFG_RISE_RUN_LENGTH: r_cfg.rise_run_length <= i_cfg_data[RUN_W-1:0];
                CFG_OVER_RUN_LENGTH: r_cfg.over_run_length <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_xfer;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    logic shift;
    assign shift = in_xfer && (i_in_data.func == FUNC_SAMPLE)
                   && (i_in_data.adc_sample != SATURATED_SAMPLE);

    // window as a chain of cells, oldest sample at the far end
    logic [SAMPLE_W-1:0] chain [WINDOW_DEPTH+1];
    assign chain[0] = i_in_data.adc_sample;

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        aclimd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_data  (chain[g]),
            .o_data  (chain[g+1])
        );
    end

    logic [TOT_W-1:0] r_total;
    logic [TOT_W-1:0] n_total;

    always_comb begin
        n_total = r_total;
        if (shift) begin
            n_total = r_total - TOT_W'(chain[WINDOW_DEPTH]) + TOT_W'(i_in_data.adc_sample);
        end
    end

    logic [FUNC_W-1:0] r_s1_func;
    logic              r_s1_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_total <= n_total;
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_func  <= i_in_data.func;
            r_s1_taken <= shift;
        end
    end

    // exact truncated mean by reciprocal multiply
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] mean;
    assign prod = PROD_W'(r_total) * PROD_W'(RECIP_C);
    assign mean = prod[SHIFT +: SAMPLE_W];

    t_judge_cmd cmd;
    logic       flag;

    always_comb begin
        cmd.judge   = 1'b0;
        cmd.restart = 1'b0;
        cmd.clear   = 1'b0;
        cmd.mean    = mean;
        case (r_s1_func)
            FUNC_SAMPLE:  cmd.judge   = r_s1_taken;
            FUNC_RESTART: cmd.restart = 1'b1;
            FUNC_CLEAR:   cmd.clear   = 1'b1;
            default: ;
        endcase
    end

    aclimd_judge u_judge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_adv),
        .i_cmd   (cmd),
        .i_cfg   (r_cfg),
        .o_flag  (flag)
    );

    // output register
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.mean_current  <= mean;
            r_out.limit_reached <= flag;
            r_out.sample_taken  <= r_s1_taken;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: test/tb_actuator_current_limit_detector_unit.sv
module tb_actuator_current_limit_detector_unit;
    import aclimd_pkg::*;

    localparam int WINDOW_DEPTH = 10;

    class limit_status_board;
        logic [SAMPLE_W-1:0] window [WINDOW_DEPTH];
        int unsigned         slot;
        logic [15:0]         total;
        logic [SAMPLE_W-1:0] last_mean;
        logic [RUN_W-1:0]    over_run;
        logic [RUN_W-1:0]    rise_run;
        logic                flag;
        t_cfg                cfg;
        t_out                expected_status [$];
        int                  mismatches;

        function new();
            foreach (window[i]) window[i] = '0;
            slot       = 0;
            total      = '0;
            last_mean  = '0;
            over_run   = '0;
            rise_run   = '0;
            flag       = 1'b0;
            mismatches = 0;
            cfg.stop_current    = RST_STOP_CURRENT;
            cfg.rise_difference = RST_RISE_DIFFERENCE;
            cfg.rise_run_length = RST_RISE_RUN_LENGTH;
            cfg.over_run_length = RST_OVER_RUN_LENGTH;
        endfunction

        function void note_item(t_in item);
            logic [SAMPLE_W-1:0] mean;
            logic                taken;
            t_out                status;
            taken = 1'b0;
            case (item.func)
                FUNC_SAMPLE: begin
                    if (item.adc_sample != SATURATED_SAMPLE) begin
                        total        = total - window[slot] + item.adc_sample;
                        window[slot] = item.adc_sample;
                        slot         = (slot + 1) % WINDOW_DEPTH;
                        taken        = 1'b1;
                        mean         = SAMPLE_W'(total / WINDOW_DEPTH);
                        if (mean > cfg.stop_current) begin
                            if (over_run != RUN_MAX) over_run++;
                            if (over_run >= cfg.over_run_length) flag = 1'b1;
                        end else begin
                            over_run = '0;
                        end
                        if (mean > last_mean && (mean - last_mean) > cfg.rise_difference) begin
                            if (rise_run != RUN_MAX) rise_run++;
                        end else begin
                            // a rise run that ends long enough trips the flag
                            if (rise_run > cfg.rise_run_length) flag = 1'b1;
                            rise_run = '0;
                        end
                        last_mean = mean;
                    end
                end
                FUNC_RESTART: begin
                    flag      = 1'b0;
                    last_mean = '0;
                    over_run  = '0;
                    rise_run  = '0;
                end
                FUNC_CLEAR: flag = 1'b0;
                default: ;
            endcase
            status.mean_current  = SAMPLE_W'(total / WINDOW_DEPTH);
            status.limit_reached = flag;
            status.sample_taken  = taken;
            expected_status.push_back(status);
        endfunction

        function void check_status(t_out got);
            t_out want;
            if (expected_status.size() == 0) begin
                $error("unexpected result: mean_current %0d limit_reached %0d sample_taken %0d",
                       got.mean_current, got.limit_reached, got.sample_taken);
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            if (got.mean_current !== want.mean_current) begin
                $error("mean_current: expected %0d, actual %0d",
                       want.mean_current, got.mean_current);
                mismatches++;
            end
            if (got.limit_reached !== want.limit_reached) begin
                $error("limit_reached: expected %0d, actual %0d",
                       want.limit_reached, got.limit_reached);
                mismatches++;
            end
            if (got.sample_taken !== want.sample_taken) begin
                $error("sample_taken: expected %0d, actual %0d",
                       want.sample_taken, got.sample_taken);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SAMPLE_W-1:0]  i_cfg_data  = '0;

    limit_status_board board;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                stim_left     = 0;

    actuator_current_limit_detector_unit #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_status(o_out_data);
        end
    end

    function automatic t_in make_item(logic [FUNC_W-1:0] func, logic [SAMPLE_W-1:0] sample);
        t_in item;
        item.func       = func;
        item.adc_sample = sample;
        return item;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_sample(int level);
        if (level < 0) return '0;
        if (level > int'(SATURATED_SAMPLE) - 1) return SATURATED_SAMPLE - 1'b1;
        return SAMPLE_W'(level);
    endfunction

    task automatic push_item(input t_in item);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_data  <= t_in'($urandom);
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_item(item);
        // unused codes and saturated samples leave the block untouched
        if (!(item.func > FUNC_CLEAR ||
              (item.func == FUNC_SAMPLE && item.adc_sample == SATURATED_SAMPLE))) begin
            stim_left--;
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (board.expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg s);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_STOP_CURRENT;
        i_cfg_data  <= s.stop_current;
        @(posedge i_clk);
        i_cfg_index <= CFG_RISE_DIFFERENCE;
        i_cfg_data  <= s.rise_difference;
        @(posedge i_clk);
        // junk above the narrow registers must be dropped
        i_cfg_index <= CFG_RISE_RUN_LENGTH;
        i_cfg_data  <= {8'($urandom), s.rise_run_length};
        @(posedge i_clk);
        i_cfg_index <= CFG_OVER_RUN_LENGTH;
        i_cfg_data  <= {8'($urandom), s.over_run_length};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.cfg = s;
    endtask

    function automatic t_cfg phase_settings(int phase);
        t_cfg s;
        case (phase)
            0: begin
                s.stop_current    = '0;
                s.rise_difference = '0;
                s.rise_run_length = '0;
                s.over_run_length = '0;
            end
            1: begin
                s.stop_current    = '1;
                s.rise_difference = '1;
                s.rise_run_length = 4'd14;
                s.over_run_length = '1;
            end
            default: begin
                s.stop_current    = SAMPLE_W'($urandom_range(800, 3600));
                s.rise_difference = SAMPLE_W'($urandom_range(0, 200));
                s.rise_run_length = RUN_W'($urandom_range(0, 14));
                s.over_run_length = RUN_W'($urandom_range(1, 15));
            end
        endcase
        return s;
    endfunction

    task automatic run_directed();
        push_item(make_item(FUNC_SAMPLE, 12'd0));
        push_item(make_item(FUNC_SAMPLE, 12'd1));
        push_item(make_item(FUNC_SAMPLE, SATURATED_SAMPLE));
        push_item(make_item(FUNC_SAMPLE, 12'd2048));
        push_item(make_item(FUNC_SAMPLE, 12'd2049));
        // full-scale ramp: over-limit run and a long rise run that ends on the plateau
        repeat (12) push_item(make_item(FUNC_SAMPLE, SATURATED_SAMPLE - 1'b1));
        push_item(make_item(FUNC_CLEAR, 12'd0));
        push_item(make_item(FUNC_SAMPLE, SATURATED_SAMPLE - 1'b1));
        push_item(make_item(FUNC_RESTART, SATURATED_SAMPLE));
        push_item(make_item(FUNC_UNUSED, SATURATED_SAMPLE));
        push_item(make_item(FUNC_SAMPLE, 12'd0));
        push_item(make_item(FUNC_UNUSED, 12'd0));
    endtask

    task automatic run_random(input int count);
        int kind;
        int n;
        int level;
        int step;
        int jitter;
        stim_left = count;
        while (stim_left > 0) begin
            kind = $urandom_range(9);
            n    = $urandom_range(3, 14);
            case (kind)
                0, 1, 2, 3: begin
                    level = $urandom_range(0, 2000);
                    step  = $urandom_range(0, 400);
                    repeat (n) begin
                        push_item(make_item(FUNC_SAMPLE, clamp_sample(level)));
                        level += step;
                    end
                end
                4, 5: begin
                    level = $urandom_range(0, 4094);
                    repeat (n) begin
                        jitter = $urandom_range(0, 40);
                        push_item(make_item(FUNC_SAMPLE, clamp_sample(level + jitter - 20)));
                    end
                end
                6: begin
                    level = $urandom_range(2000, 4094);
                    step  = $urandom_range(0, 400);
                    repeat (n) begin
                        push_item(make_item(FUNC_SAMPLE, clamp_sample(level)));
                        level -= step;
                    end
                end
                7: push_item(make_item(FUNC_W'($urandom_range(FUNC_RESTART, FUNC_CLEAR)),
                                       SAMPLE_W'($urandom)));
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        push_item(make_item(FUNC_W'($urandom),
                                            ($urandom_range(0, 3) == 0) ? SATURATED_SAMPLE
                                                                        : SAMPLE_W'($urandom)));
                    end
                end
            endcase
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 8;
        recv_idle_pct = 52;
        run_directed();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 52;
                recv_idle_pct = 8;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            apply_settings(phase_settings(phase));
            run_random(65);
        end
        i_in_valid <= 1'b0;
        while (board.expected_status.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_status.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
